@@ rtl/bpp_pkg.sv @@
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared types and codes of the bucketed priority pool.
// ----------------------------------------------------------------------------
`default_nettype none

package bpp_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int IN_BITS    = 361;
    localparam int OUT_BITS   = 129;
    localparam int IN_BYTES_W = 368;
    localparam int OUT_BYTES_W = 136;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_POOL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 1'd1;

    localparam logic [2:0] OP_PUSH     = 3'd0;
    localparam logic [2:0] OP_POP      = 3'd1;
    localparam logic [2:0] OP_TOP      = 3'd2;
    localparam logic [2:0] OP_ERASE    = 3'd3;
    localparam logic [2:0] OP_CONTAINS = 3'd4;
    localparam logic [2:0] OP_COUNTS   = 3'd5;
    localparam logic [2:0] OP_CLEAR    = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EVICT_NEW = 3'd4;

    // first member sits in the highest bits
    typedef struct packed {
        logic [31:0] handle;
        logic [63:0] key_word3;
        logic [63:0] key_word2;
        logic [63:0] key_word1;
        logic [63:0] key_word0;
        logic [63:0] priority_req;
        logic [5:0]  bucket;
        logic [2:0]  op;
    } t_in_item;

    typedef struct packed {
        logic [10:0] total_count;
        logic [10:0] bucket_count;
        logic        evicted;
        logic [5:0]  out_bucket;
        logic [63:0] out_priority;
        logic [31:0] out_handle;
        logic        found;
        logic [2:0]  status;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic clr_init;
        logic clr_step;
        logic decide;
        logic cnt_sel_match;
        logic evict;
        logic erase_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       scan_last;
        logic       clr_last;
        logic       evict_other;
        logic       erase_hit;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/bpp_datapath.sv @@
// ----------------------------------------------------------------------------
// bpp_datapath
// Slot store, bucket counters, scan accumulators and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_datapath import bpp_pkg::*; #(
    parameter int CAPACITY    = 1024,
    parameter int NUM_BUCKETS = 64,
    parameter int HANDLE_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_in_item              i_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    output t_out_item                  o_out
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int XW  = ((CW > 11) ? CW : 11) + 1;
    localparam int SN  = (CAPACITY > NUM_BUCKETS) ? CAPACITY : NUM_BUCKETS;
    localparam int SWW = $clog2(SN);

    typedef struct packed {
        logic [BW-1:0]          bucket;
        logic [63:0]            prio;
        logic [255:0]           key;
        logic [HANDLE_BITS-1:0] handle;
        logic [31:0]            order;
    } t_row;

    function automatic logic [BW-1:0] f_reduce(input logic [5:0] v);
        logic [BW-1:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) begin
            if (v == 6'(i)) r = BW'(i % NUM_BUCKETS);
        end
        return r;
    endfunction

    function automatic logic [10:0] f_c11(input logic [CW-1:0] c);
        logic [XW-1:0] x;
        x = XW'(c);
        return x[10:0];
    endfunction

    logic              r_valid_mem [CAPACITY];
    t_row              r_data_mem  [CAPACITY];
    logic [CW-1:0]     r_cnt_mem   [NUM_BUCKETS];

    logic [2:0]        r_op;
    logic [BW-1:0]     r_b;
    logic [63:0]       r_prio;
    logic [255:0]      r_key;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [10:0]       r_max;
    logic [10:0]       r_rsv;
    logic [CW-1:0]     r_pool, n_pool;
    logic [31:0]       r_seq, n_seq;
    logic [AW-1:0]     r_addr;
    logic [SWW-1:0]    r_swp;

    logic              r_rd_v;
    t_row              r_rd;
    logic              r_rd_live;
    logic [AW-1:0]     r_rd_idx;
    logic [CW-1:0]     r_cnt_rd;

    logic              r_match_hit;
    logic [AW-1:0]     r_match_idx;
    logic [BW-1:0]     r_match_bucket;
    logic              r_free_hit;
    logic [AW-1:0]     r_free_idx;
    logic              r_best_hit;
    logic [AW-1:0]     r_best_idx;
    logic [63:0]       r_best_prio;
    logic [31:0]       r_best_order;
    logic [HANDLE_BITS-1:0] r_best_handle;
    logic              r_worst_hit;
    logic [AW-1:0]     r_worst_idx;
    logic [63:0]       r_worst_prio;
    logic [31:0]       r_worst_order;

    t_out_item         r_res, n_res;
    t_out_item         r_out;

    logic              w_v_we, w_v_wd, w_d_we, w_c_we;
    logic [AW-1:0]     w_v_wa;
    logic [BW-1:0]     w_c_wa, w_c_ra;
    logic [CW-1:0]     w_c_wd;
    t_row              w_row_new;
    logic [63:0]       w_h_in, w_h_best;
    logic [7:0]        w_b8;
    logic              w_swp_v, w_swp_c;
    logic              w_ins_ok, w_cond, w_new_worst, w_evict;
    logic              w_rd_in_b, w_better, w_worse;

    assign w_h_in   = 64'(i_item.handle);
    assign w_h_best = 64'(r_best_handle);
    assign w_b8     = 8'(r_b);
    assign w_swp_v  = {1'b0, r_swp} < (SWW + 1)'(CAPACITY);
    assign w_swp_c  = {1'b0, r_swp} < (SWW + 1)'(NUM_BUCKETS);
    assign w_c_ra   = i_cmd.cnt_sel_match ? r_match_bucket : r_b;

    assign w_row_new = '{bucket: r_b, prio: r_prio, key: r_key, handle: r_handle, order: r_seq};

    assign w_rd_in_b = r_rd_v && (r_rd.bucket == r_b);
    assign w_better  = (r_rd.prio < r_best_prio) ||
                       ((r_rd.prio == r_best_prio) && (r_rd.order < r_best_order));
    assign w_worse   = (r_rd.prio > r_worst_prio) ||
                       ((r_rd.prio == r_worst_prio) && (r_rd.order > r_worst_order));

    assign w_ins_ok    = !r_match_hit && r_free_hit;
    assign w_cond      = ((XW'(r_pool) + XW'(1)) > XW'(r_max)) &&
                         ((XW'(r_cnt_rd) + XW'(1)) > XW'(r_rsv));
    assign w_new_worst = !r_worst_hit || (r_prio > r_worst_prio) ||
                         ((r_prio == r_worst_prio) && (r_seq > r_worst_order));
    assign w_evict     = w_ins_ok && w_cond;

    assign o_sts.op          = r_op;
    assign o_sts.scan_last   = (r_addr == AW'(CAPACITY - 1));
    assign o_sts.clr_last    = (r_swp == SWW'(SN - 1));
    assign o_sts.evict_other = (r_op == OP_PUSH) && w_evict && !w_new_worst;
    assign o_sts.erase_hit   = (r_op == OP_ERASE) && r_match_hit;
    assign o_out = r_out;

    always_comb begin
        w_v_we = 1'b0;
        w_v_wa = r_addr;
        w_v_wd = 1'b0;
        w_d_we = 1'b0;
        w_c_we = 1'b0;
        w_c_wa = r_b;
        w_c_wd = r_cnt_rd;
        n_res  = r_res;
        n_pool = r_pool;
        n_seq  = r_seq;
        if (i_cmd.clr_step) begin
            w_v_we = w_swp_v;
            w_v_wa = r_swp[AW-1:0];
            w_c_we = w_swp_c;
            w_c_wa = r_swp[BW-1:0];
            w_c_wd = '0;
        end
        if (i_cmd.decide) begin
            n_res = '0;
            n_res.bucket_count = f_c11(r_cnt_rd);
            n_res.total_count  = f_c11(r_pool);
            case (r_op)
                OP_PUSH: begin
                    if (r_match_hit) begin
                        n_res.status = ST_DUPLICATE;
                    end else if (!r_free_hit) begin
                        n_res.status = ST_FULL;
                    end else begin
                        n_seq = r_seq + 32'd1;
                        n_res.evicted = w_evict;
                        if (w_evict && w_new_worst) begin
                            n_res.status = ST_EVICT_NEW;
                        end else begin
                            n_res.found = 1'b1;
                            w_d_we = 1'b1;
                            w_v_we = 1'b1;
                            w_v_wa = r_free_idx;
                            w_v_wd = 1'b1;
                        end
                        if (!w_evict) begin
                            n_pool = r_pool + CW'(1);
                            w_c_we = 1'b1;
                            w_c_wd = r_cnt_rd + CW'(1);
                            n_res.bucket_count = f_c11(w_c_wd);
                            n_res.total_count  = f_c11(n_pool);
                        end
                    end
                end
                OP_POP, OP_TOP: begin
                    if (r_best_hit) begin
                        n_res.found        = 1'b1;
                        n_res.out_handle   = w_h_best[31:0];
                        n_res.out_priority = r_best_prio;
                        n_res.out_bucket   = w_b8[5:0];
                        if (r_op == OP_POP) begin
                            w_v_we = 1'b1;
                            w_v_wa = r_best_idx;
                            n_pool = r_pool - CW'(1);
                            w_c_we = 1'b1;
                            w_c_wd = r_cnt_rd - CW'(1);
                            n_res.bucket_count = f_c11(w_c_wd);
                            n_res.total_count  = f_c11(n_pool);
                        end
                    end else begin
                        n_res.status = ST_NOT_FOUND;
                    end
                end
                OP_ERASE: begin
                    if (r_match_hit) begin
                        n_res.found = 1'b1;
                        w_v_we = 1'b1;
                        w_v_wa = r_match_idx;
                        n_pool = r_pool - CW'(1);
                        n_res.total_count = f_c11(n_pool);
                    end else begin
                        n_res.status = ST_NOT_FOUND;
                    end
                end
                OP_CONTAINS: begin
                    if (r_match_hit) n_res.found = 1'b1;
                    else n_res.status = ST_NOT_FOUND;
                end
                OP_CLEAR: begin
                    n_res.bucket_count = '0;
                    n_res.total_count  = '0;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.evict) begin
            w_v_we = 1'b1;
            w_v_wa = r_worst_idx;
            w_v_wd = 1'b0;
        end
        if (i_cmd.erase_wr) begin
            w_c_we = 1'b1;
            w_c_wa = r_match_bucket;
            w_c_wd = r_cnt_rd - CW'(1);
            if (r_match_bucket == r_b) n_res.bucket_count = r_res.bucket_count - 11'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_v_we) r_valid_mem[w_v_wa] <= w_v_wd;
        if (w_d_we) r_data_mem[r_free_idx] <= w_row_new;
        if (w_c_we) r_cnt_mem[w_c_wa] <= w_c_wd;
        r_rd_v   <= r_valid_mem[r_addr];
        r_rd     <= r_data_mem[r_addr];
        r_rd_idx <= r_addr;
        r_cnt_rd <= r_cnt_mem[w_c_ra];
        r_res    <= n_res;
        if (i_cmd.out_load) r_out <= r_res;
        if (i_cmd.load) begin
            r_op     <= i_item.op;
            r_b      <= f_reduce(i_item.bucket);
            r_prio   <= i_item.priority_req;
            r_key    <= {i_item.key_word3, i_item.key_word2, i_item.key_word1,
                         i_item.key_word0};
            r_handle <= w_h_in[HANDLE_BITS-1:0];
        end
        if (r_rd_live && r_rd_v && (r_rd.key == r_key) && !r_match_hit) begin
            r_match_idx    <= r_rd_idx;
            r_match_bucket <= r_rd.bucket;
        end
        if (r_rd_live && !r_rd_v && !r_free_hit) r_free_idx <= r_rd_idx;
        if (r_rd_live && w_rd_in_b && (!r_best_hit || w_better)) begin
            r_best_idx    <= r_rd_idx;
            r_best_prio   <= r_rd.prio;
            r_best_order  <= r_rd.order;
            r_best_handle <= r_rd.handle;
        end
        if (r_rd_live && w_rd_in_b && (!r_worst_hit || w_worse)) begin
            r_worst_idx   <= r_rd_idx;
            r_worst_prio  <= r_rd.prio;
            r_worst_order <= r_rd.order;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= 11'd256;
            r_rsv       <= 11'd16;
            r_pool      <= '0;
            r_seq       <= '0;
            r_addr      <= '0;
            r_swp       <= '0;
            r_rd_live   <= 1'b0;
            r_match_hit <= 1'b0;
            r_free_hit  <= 1'b0;
            r_best_hit  <= 1'b0;
            r_worst_hit <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == REG_MAX_POOL)) r_max <= i_cfg_data;
            if (i_cfg_we && (i_cfg_idx == REG_RESERVED)) r_rsv <= i_cfg_data;
            r_pool    <= n_pool;
            r_seq     <= n_seq;
            r_rd_live <= i_cmd.scan_step;
            if (i_cmd.clr_init) begin
                r_swp  <= '0;
                r_pool <= '0;
                r_seq  <= '0;
            end else if (i_cmd.clr_step) begin
                r_swp <= r_swp + SWW'(1);
            end
            if (i_cmd.scan_init) begin
                r_addr      <= '0;
                r_match_hit <= 1'b0;
                r_free_hit  <= 1'b0;
                r_best_hit  <= 1'b0;
                r_worst_hit <= 1'b0;
            end else begin
                if (i_cmd.scan_step) r_addr <= r_addr + AW'(1);
                if (r_rd_live && r_rd_v && (r_rd.key == r_key)) r_match_hit <= 1'b1;
                if (r_rd_live && !r_rd_v) r_free_hit <= 1'b1;
                if (r_rd_live && w_rd_in_b) begin
                    r_best_hit  <= 1'b1;
                    r_worst_hit <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/bpp_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpp_ctrl
// Sequencer: clearing sweep, slot scan, update steps and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_ctrl import bpp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_valid,
    input  wire logic [2:0] i_in_op,
    input  wire logic       i_m_ready,
    input  wire t_sts       i_sts,
    output logic            o_s_ready,
    output logic            o_m_valid,
    output t_cmd            o_cmd
);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_SCAN, S_WAIT, S_DECIDE, S_EVICT, S_EWR, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_boot, n_boot;
    logic   r_mvalid, n_mvalid;
    logic   w_acc;

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_mvalid;
    assign w_acc     = i_s_valid && o_s_ready;

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_boot   = r_boot;
        n_mvalid = r_mvalid && !i_m_ready;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_boot ? S_IDLE : S_DECIDE;
                    n_boot  = 1'b0;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.load = 1'b1;
                    case (i_in_op)
                        OP_CLEAR: begin
                            o_cmd.clr_init = 1'b1;
                            n_state = S_CLR;
                        end
                        OP_PUSH, OP_POP, OP_TOP, OP_ERASE, OP_CONTAINS: begin
                            o_cmd.scan_init = 1'b1;
                            n_state = S_SCAN;
                        end
                        default: n_state = S_WAIT;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_WAIT;
            end
            S_WAIT: n_state = S_DECIDE;
            S_DECIDE: begin
                o_cmd.decide        = 1'b1;
                o_cmd.cnt_sel_match = (i_sts.op == OP_ERASE);
                if (i_sts.evict_other) n_state = S_EVICT;
                else if (i_sts.erase_hit) n_state = S_EWR;
                else n_state = S_OUT;
            end
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state = S_OUT;
            end
            S_EWR: begin
                o_cmd.erase_wr = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_mvalid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_mvalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_boot   <= 1'b1;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_boot   <= n_boot;
            r_mvalid <= n_mvalid;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bucketed_priority_pool.sv @@
// ----------------------------------------------------------------------------
// bucketed_priority_pool
// Keyed pool of prioritized entries in buckets, with eviction on overflow.
// ----------------------------------------------------------------------------
// Usage:
//   One command per transaction on the s_axis side (push, pop, top, erase,
//   contains, counts, clear); exactly one result transaction per command on
//   the m_axis side. Configuration writes go through i_cfg_* while idle.
//   Push, pop, top, erase and contains scan every slot of the store, one slot
//   per cycle through its single read port; a push that evicts an older entry
//   passes through S_EVICT and an erase that hits passes through S_EWR.
//   A counts query skips the scan. Clear sweeps the valid bits and bucket
//   counters. After reset the same sweep runs with s_axis_tready low.
//   One command is in work at a time; the next is taken as soon as the
//   previous result sits in the output register, even if the receiver
//   stalls it. A stalled result holds its data; a finished command waits
//   for the output register to free before handing over.
// ----------------------------------------------------------------------------
`default_nettype none

module bucketed_priority_pool import bpp_pkg::*; #(
    parameter int CAPACITY    = 1024,
    parameter int NUM_BUCKETS = 64,
    parameter int HANDLE_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // op[2:0], bucket[8:3], priority_req[72:9], key_word0..3[328:73],
    // handle[360:329], zero pad
    input  wire logic [IN_BYTES_W-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // status[2:0], found[3], out_handle[35:4], out_priority[99:36],
    // out_bucket[105:100], evicted[106], bucket_count[117:107],
    // total_count[128:118], zero pad
    output logic [OUT_BYTES_W-1:0]     m_axis_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_in_item  w_item;
    t_out_item w_out;
    t_cmd      w_cmd;
    t_sts      w_sts;

    assign w_item       = t_in_item'(s_axis_tdata[IN_BITS-1:0]);
    assign m_axis_tdata = {(OUT_BYTES_W - OUT_BITS)'(0), w_out};

    bpp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_in_op   (w_item.op),
        .i_m_ready (m_axis_tready),
        .i_sts     (w_sts),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (w_cmd)
    );

    bpp_datapath #(
        .CAPACITY    (CAPACITY),
        .NUM_BUCKETS (NUM_BUCKETS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (w_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out      (w_out)
    );

endmodule

`default_nettype wire

@@ rtl/bpp_checker.sv @@
// ----------------------------------------------------------------------------
// bpp_checker
// Port-level checks of the bucketed priority pool.
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_checker import bpp_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_tvalid,
    input wire logic                   i_s_tready,
    input wire logic                   i_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_BYTES_W-1:0] i_m_tdata
);

    t_out_item w_res;
    assign w_res = t_out_item'(i_m_tdata[OUT_BITS-1:0]);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("command taken while another is in work");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && w_res.found |-> w_res.status == ST_OK)
        else $error("found with error status");

    a_evict_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && w_res.status == ST_EVICT_NEW |-> w_res.evicted && !w_res.found)
        else $error("inconsistent eviction report");

    a_payload_only_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !w_res.found |-> w_res.out_handle == 32'd0 &&
        w_res.out_priority == 64'd0)
        else $error("payload on a miss");

endmodule

bind bucketed_priority_pool bpp_checker u_bpp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

`default_nettype wire
